/* src/greedy_line_breaker_assert.svh */
// Assertion macros shared by the line breaker RTL.
`ifndef GREEDY_LINE_BREAKER_ASSERT_SVH
`define GREEDY_LINE_BREAKER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GLB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define GLB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/glb_pkg.sv */
// Package of the line breaker: payload types, character codes and sizes.
package glb_pkg;
    localparam int MAX_LINES_DEF     = 256;
    localparam int PENDING_DEPTH_DEF = 256;
    localparam int OUT_DEPTH         = 4;
    localparam int MAX_RESULTS       = 4;
    localparam int ENTRY_W           = 24;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_HYPHEN  = 8'd45;

    localparam logic REG_WRAP_WIDTH  = 1'b0;
    localparam logic REG_LINE_HEIGHT = 1'b1;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [15:0] char_width;
        logic        end_of_text;
    } t_in;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] line_begin;
        logic [15:0] line_len;
        logic [31:0] line_px;
        logic [8:0]  lines_so_far;
        logic [31:0] widest_px;
        logic [31:0] total_px;
        logic        final_flag;
        logic        overflow_flag;
    } t_out;
endpackage

/* src/glb_pending_ram.sv */
// Held-character memory: one write port, one read port, registered read data.
module glb_pending_ram #(
    parameter int DEPTH = glb_pkg::PENDING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [glb_pkg::ENTRY_W-1:0]     i_wdata,
    input  logic                            i_re,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [glb_pkg::ENTRY_W-1:0]     o_rdata
);
    import glb_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/glb_out_fifo.sv */
// Small result queue between the line engine and the output channel.
module glb_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  glb_pkg::t_out i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output glb_pkg::t_out o_data
);
    import glb_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);

    t_out            r_q [OUT_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            pop;

    assign o_full  = (r_cnt == (PW+1)'(OUT_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end
endmodule

/* src/greedy_line_breaker.sv */
// Greedy line breaker: splits a character stream into line and summary records.
// Flow: an accepted item passes the step, finish and flush states up to the last result queued;
// a wrap replays each held character through the read, data and step states, a forced break repeats the step.
// End of text adds the last line, height product and summary states.
// A new item is taken only in idle, after the last one is flushed; a full result queue stalls the steps.
// Reset: synchronous, active low; clears text state and control registers, not the payload registers or held memory.
module greedy_line_breaker #(
    parameter int MAX_LINES     = glb_pkg::MAX_LINES_DEF,
    parameter int PENDING_DEPTH = glb_pkg::PENDING_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  glb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output glb_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import glb_pkg::*;

    localparam int HW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = $clog2(PENDING_DEPTH);
    localparam int LW = $clog2(MAX_LINES + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROC  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RX    = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_EOL   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0]  r_state, n_state;

    // configuration
    logic [15:0] r_ww, r_lh;

    // text state
    logic [15:0] r_pos, n_pos, r_start, n_start, r_bidx, n_bidx;
    logic [31:0] r_rw, n_rw, r_bpx, n_bpx, r_widest, n_widest;
    logic        r_bv, n_bv, r_cap, n_cap, r_ovf, n_ovf, r_skip, n_skip;
    logic [HW-1:0] r_held, n_held;
    logic [LW-1:0] r_lines, n_lines;

    // current item and character under work
    logic [7:0]  r_ic, n_ic, r_cc, n_cc;
    logic [15:0] r_iw, n_iw, r_cw, n_cw, r_cp, n_cp;
    logic        r_eot, n_eot;

    // replay control
    logic          r_inrp, n_inrp, r_tail, n_tail;
    logic [HW-1:0] r_k, n_k, r_n, n_n;
    logic [15:0]   r_brk, n_brk;

    // summary product
    logic [LW+15:0] r_prod, n_prod;

    // result hold stage
    t_out        r_hold, n_hold;
    logic        r_hv, n_hv;
    logic [RW-1:0] r_rcnt, n_rcnt;

    // memory port
    logic               mem_we, mem_re;
    logic [ENTRY_W-1:0] mem_rdata;

    // emission
    logic        e_valid, e_line, e_kind, flush, push, fifo_full, go;
    logic [15:0] e_begin, e_end;
    logic [31:0] e_px, e_total;
    t_out        rec, push_rec;

    // step helpers
    logic [32:0] sum33;
    logic [31:0] rwn, pre, sel_px;
    logic        brkable, stored, wrap, bv_new, tail_w;
    logic [15:0] bidx_new, brkpos;
    logic [31:0] bpx_new;
    logic [HW-1:0] held_new, k_inc;
    logic [63:0] prod64;
    logic [31:0] lines32;

    assign go         = !fifo_full;
    assign o_in_ready = (r_state == S_IDLE);

    glb_pending_ram #(.DEPTH(PENDING_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_held[AW-1:0]),
        .i_wdata ({r_cc, r_cw}),
        .i_re    (mem_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    glb_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .o_full  (fifo_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // one step of the character under work, used in S_PROC
    always_comb begin
        pre      = r_rw;
        sum33    = {1'b0, r_rw} + {17'b0, r_cw};
        rwn      = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
        brkable  = (r_cc == CH_SPACE) || (r_cc == CH_TAB) || (r_cc == CH_HYPHEN);
        stored   = !brkable && (r_held < HW'(PENDING_DEPTH));
        bidx_new = brkable ? r_cp : r_bidx;
        bv_new   = brkable ? (r_cp != r_start) : r_bv;
        bpx_new  = brkable ? rwn : r_bpx;
        held_new = brkable ? '0 : (r_held + HW'(stored));
        wrap     = (r_ww != 16'd0) && (rwn > {16'b0, r_ww}) && (r_cp != r_start);
        brkpos   = bv_new ? (bidx_new + 16'd1) : r_cp;
        sel_px   = bv_new ? bpx_new : pre;
        tail_w   = bv_new ? (!brkable && !stored) : 1'b1;
        k_inc    = r_k + 1'b1;
        prod64   = 64'(r_prod);
    end

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;   n_start = r_start; n_bidx = r_bidx;
        n_rw = r_rw;     n_bpx = r_bpx;     n_widest = r_widest;
        n_bv = r_bv;     n_cap = r_cap;     n_ovf = r_ovf;  n_skip = r_skip;
        n_held = r_held; n_lines = r_lines;
        n_ic = r_ic; n_iw = r_iw; n_eot = r_eot;
        n_cc = r_cc; n_cw = r_cw; n_cp = r_cp;
        n_inrp = r_inrp; n_tail = r_tail; n_k = r_k; n_n = r_n; n_brk = r_brk;
        n_prod = r_prod;
        mem_we = 1'b0; mem_re = 1'b0;
        e_valid = 1'b0; e_line = 1'b0; e_kind = KIND_LINE; flush = 1'b0;
        e_begin = '0; e_end = '0; e_px = '0; e_total = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ic = i_in_data.char_code;
                    n_iw = i_in_data.char_width;
                    n_eot = i_in_data.end_of_text;
                    n_cc = i_in_data.char_code;
                    n_cw = i_in_data.char_width;
                    n_cp = r_pos;
                    n_inrp = 1'b0;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (go) begin
                    // default: character finished; advance the replay or wrap up
                    if (r_inrp) begin
                        n_k = k_inc;
                        if (k_inc < r_n) begin
                            n_state = S_RD;
                        end else if (r_tail) begin
                            n_cc = r_ic; n_cw = r_iw; n_cp = r_pos;
                            n_inrp = 1'b0;
                        end else begin
                            n_inrp = 1'b0;
                            n_state = S_FIN;
                        end
                    end else begin
                        n_state = S_FIN;
                    end

                    if (r_cap) begin
                        // past the line cap: drop the character
                    end else if (r_skip && r_cc == CH_SPACE) begin
                        n_start = r_cp + 16'd1;
                    end else if (r_cc == CH_NEWLINE) begin
                        n_skip = 1'b0;
                        e_line = 1'b1; e_begin = r_start; e_end = r_cp; e_px = r_rw;
                        n_start = r_cp + 16'd1;
                        n_bv = 1'b0; n_rw = '0; n_held = '0;
                    end else begin
                        n_skip = 1'b0;
                        n_rw = rwn; n_bidx = bidx_new; n_bv = bv_new;
                        n_bpx = bpx_new; n_held = held_new;
                        mem_we = stored;
                        if (!brkable && !stored) begin
                            n_ovf = 1'b1;
                        end
                        if (wrap) begin
                            e_line = 1'b1; e_begin = r_start; e_end = brkpos; e_px = sel_px;
                            n_start = brkpos; n_bv = 1'b0; n_rw = '0; n_held = '0;
                            n_skip = 1'b1;
                            if (bv_new && held_new != '0) begin
                                // replay the held characters from the new line start
                                n_inrp = 1'b1; n_k = '0; n_n = held_new;
                                n_brk = brkpos; n_tail = tail_w;
                                n_state = S_RD;
                            end else if (tail_w) begin
                                // hold the character and take it again on the new line
                                n_state = S_PROC;
                                n_k = r_k; n_inrp = r_inrp;
                                n_cc = r_cc; n_cw = r_cw; n_cp = r_cp;
                            end
                        end
                    end
                end
            end
            S_RD: begin
                mem_re = 1'b1;
                n_state = S_RX;
            end
            S_RX: begin
                n_cc = mem_rdata[23:16];
                n_cw = mem_rdata[15:0];
                n_cp = r_brk + 16'(r_k);
                n_state = S_PROC;
            end
            S_FIN: begin
                n_pos = r_pos + 16'd1;
                n_state = r_eot ? S_EOL : S_FLUSH;
            end
            S_EOL: begin
                if (go) begin
                    if (!r_cap && r_pos != r_start) begin
                        e_line = 1'b1; e_begin = r_start; e_end = r_pos; e_px = r_rw;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = r_lines * r_lh;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (go) begin
                    e_valid = 1'b1; e_kind = KIND_SUMMARY;
                    e_total = (prod64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod64[31:0];
                    // clear the text state for the next text
                    n_pos = '0; n_start = '0; n_bidx = '0; n_rw = '0; n_bpx = '0;
                    n_bv = 1'b0; n_cap = 1'b0; n_ovf = 1'b0; n_skip = 1'b0;
                    n_held = '0; n_lines = '0; n_widest = '0;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (go) begin
                    flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (e_line) begin
            e_valid = 1'b1;
            n_lines = r_lines + 1'b1;
            if (n_lines >= LW'(MAX_LINES)) begin
                n_cap = 1'b1;
            end
            if (e_px > r_widest) begin
                n_widest = e_px;
            end
        end
    end

    // build the record from the updated counters; summary takes them before clearing
    always_comb begin
        lines32 = 32'(e_line ? n_lines : r_lines);
        rec.record_kind   = e_kind;
        rec.line_begin    = e_begin;
        rec.line_len      = e_end - e_begin;
        rec.line_px       = e_px;
        rec.lines_so_far  = lines32[8:0];
        rec.widest_px     = e_line ? n_widest : r_widest;
        rec.total_px      = e_total;
        rec.final_flag    = 1'b0;
        rec.overflow_flag = e_kind ? r_ovf : n_ovf;

        n_hold = r_hold; n_hv = r_hv; n_rcnt = r_rcnt;
        push = 1'b0; push_rec = r_hold;
        if (flush) begin
            // mark the last kept result of this item
            push = r_hv;
            push_rec.final_flag = 1'b1;
            n_hv = 1'b0; n_rcnt = '0;
        end else if (e_valid && r_rcnt < RW'(MAX_RESULTS)) begin
            push = r_hv;
            n_hold = rec; n_hv = 1'b1;
            n_rcnt = r_rcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ww <= '0; r_lh <= '0;
            r_pos <= '0; r_start <= '0; r_bidx <= '0;
            r_rw <= '0; r_bpx <= '0; r_widest <= '0;
            r_bv <= 1'b0; r_cap <= 1'b0; r_ovf <= 1'b0; r_skip <= 1'b0;
            r_held <= '0; r_lines <= '0;
            r_inrp <= 1'b0; r_k <= '0; r_n <= '0;
            r_hv <= 1'b0; r_rcnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WRAP_WIDTH) begin
                    r_ww <= i_cfg_data;
                end else begin
                    r_lh <= i_cfg_data;
                end
            end
            r_pos <= n_pos; r_start <= n_start; r_bidx <= n_bidx;
            r_rw <= n_rw; r_bpx <= n_bpx; r_widest <= n_widest;
            r_bv <= n_bv; r_cap <= n_cap; r_ovf <= n_ovf; r_skip <= n_skip;
            r_held <= n_held; r_lines <= n_lines;
            r_inrp <= n_inrp; r_k <= n_k; r_n <= n_n;
            r_hv <= n_hv; r_rcnt <= n_rcnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ic <= n_ic; r_iw <= n_iw; r_eot <= n_eot;
        r_cc <= n_cc; r_cw <= n_cw; r_cp <= n_cp;
        r_tail <= n_tail; r_brk <= n_brk;
        r_prod <= n_prod;
        r_hold <= n_hold;
    end

    `include "greedy_line_breaker_assert.svh"

    `GLB_ASSERT_IMP(a_held_bound, 1'b1, r_held <= HW'(PENDING_DEPTH), "held count past depth")
    `GLB_ASSERT_IMP(a_rx_after_rd, r_state == S_RX, $past(r_state) == S_RD, "data without read")
    `GLB_ASSERT_IMP(a_rd_in_range, r_state == S_RD, r_inrp && r_k < r_n, "replay read past count")
    `GLB_ASSERT_NXT(a_accept_proc, i_in_valid && o_in_ready, r_state == S_PROC, "item not taken")
endmodule
